>>> hdl/assert_macros.svh
// Assertion macros shared by the controller port responder RTL.
// No dependencies; pulled in by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, gated off while reset is low
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> hdl/pmc_pkg.sv
// Types and constants for the pad and memory card port responder.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package pmc_pkg;

  // Input word: one host byte exchange with its side-band state
  typedef struct packed {
    logic [7:0]  host_byte;
    logic        port_selected;
    logic [15:0] button_bits;
    logic        buttons_valid;
  } in_word_t;

  // Result word: reply byte and acknowledge
  typedef struct packed {
    logic [7:0] reply_byte;
    logic       more_follows;
  } out_word_t;

  // Configuration port
  typedef logic [0:0] cfg_idx_t;
  typedef logic [1:0] cfg_data_t;

  localparam cfg_idx_t CFG_PAD_KIND      = 1'd0;
  localparam cfg_idx_t CFG_CARD_INSERTED = 1'd1;

  // Pad kinds
  localparam logic [1:0] PAD_NONE    = 2'd0;
  localparam logic [1:0] PAD_DIGITAL = 2'd1;

  // Card operations
  typedef logic [1:0] card_op_t;
  localparam card_op_t OP_READ  = 2'd0;
  localparam card_op_t OP_ID    = 2'd1;
  localparam card_op_t OP_WRITE = 2'd2;

  // Protocol bytes
  localparam logic [7:0] BYTE_IDLE      = 8'hFF;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] CMD_PAD        = 8'h01;
  localparam logic [7:0] CMD_CARD       = 8'h81;
  localparam logic [7:0] CMD_POLL       = 8'h42;
  localparam logic [7:0] CMD_READ       = 8'h52;
  localparam logic [7:0] CMD_ID         = 8'h53;
  localparam logic [7:0] CMD_WRITE      = 8'h57;
  localparam logic [7:0] PAD_ID_LO      = 8'h41;
  localparam logic [7:0] ID_5A          = 8'h5A;
  localparam logic [7:0] ID_5D          = 8'h5D;
  localparam logic [7:0] ID_5C          = 8'h5C;
  localparam logic [7:0] END_GOOD       = 8'h47;
  localparam logic [7:0] END_BAD        = 8'h4E;
  localparam logic [7:0] FLAG_RESET     = 8'h08;
  localparam logic [7:0] FLAG_FRESH_BIT = 8'h08;

  // Reply sequence of the card ID command, indexed by step minus two
  function automatic logic [7:0] id_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = ID_5A;
      3'd1: b = ID_5D;
      3'd2: b = ID_5C;
      3'd3: b = ID_5D;
      3'd4: b = 8'h04;
      3'd5: b = 8'h00;
      3'd6: b = 8'h00;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

endpackage

>>> hdl/pmc_ifs.sv
// Valid/ready channel interfaces for the port responder's input and result words.
// Depends on pmc_pkg for the word types.
`timescale 1ns / 1ps

interface pmc_in_if;
  import pmc_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pmc_out_if;
  import pmc_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/pmc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 131072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/pad_and_memory_card_responder.sv
// Device side of one controller port: a digital pad and a memory card.
// Depends on pmc_pkg, pmc_ifs, pmc_ram and assert_macros.svh.
//
// One input word is one byte exchange; it yields one result word (reply byte and acknowledge).
// A word is taken every clock but for the stalls below: the exchange is decided in the
// accept cycle and the result is offered from an output register on the next clock. A new
// word enters while no result waits or in the clock that the waiting result is taken;
// while a result waits untaken, input stalls. The card store lives in a RAM with a
// registered read. Its read address always follows the next byte pointer, so the byte for
// the following read step is fetched ahead; card writes go to the current pointer, which
// never equals the prefetched address. After reset a clearing pass zeroes the store's
// CARD_BYTES bytes (131072 by default), during which only configuration writes are taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pad_and_memory_card_responder #(
  parameter int CARD_BYTES = 131072
) (
  input  logic                clk,
  input  logic                rst_n,
  pmc_in_if.sink              in_chan,
  pmc_out_if.source           out_chan,
  input  logic                cfg_we,
  input  pmc_pkg::cfg_idx_t   cfg_index,
  input  pmc_pkg::cfg_data_t  cfg_data
);
  import pmc_pkg::*;

  localparam int ADDR_W = $clog2(CARD_BYTES);

  // State registers
  logic [7:0]        step_r, step_nxt;
  logic              was_sel_r, was_sel_nxt;
  logic              card_mode_r, card_mode_nxt;
  card_op_t          card_op_r, card_op_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic [7:0]        echo_r, echo_nxt;
  logic [1:0]        sect_hi_r, sect_hi_nxt;
  logic [7:0]        sect_lo_r, sect_lo_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [7:0]        flag_r, flag_nxt;
  logic [1:0]        pad_kind_r, pad_kind_nxt;
  logic              card_ins_r, card_ins_nxt;

  // Clearing pass
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_cnt_r;

  // Output register
  logic              out_valid_r;
  out_word_t         out_word_r;

  // Exchange datapath
  logic              acc;
  logic [7:0]        c;
  logic              sel;
  logic [7:0]        s;
  logic [7:0]        s_inc;
  logic [7:0]        reply;
  logic              ack;
  logic              item_we;
  logic [ADDR_W-1:0] base_cur;
  logic [ADDR_W-1:0] base_new;

  // Card store port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  assign in_chan.ready = !clearing_r && (!out_valid_r || out_chan.ready);
  assign acc   = in_chan.valid && in_chan.ready;
  assign c     = in_chan.data.host_byte;
  assign sel   = in_chan.data.port_selected;
  // A fresh select restarts the sequence
  assign s     = (sel && !was_sel_r) ? 8'd0 : step_r;
  assign s_inc = s + 8'd1;
  assign base_cur = ADDR_W'({sect_hi_r, sect_lo_r, 7'b0});
  assign base_new = ADDR_W'({sect_hi_r, c, 7'b0});

  // Decide one exchange and the configuration writes
  always_comb begin
    step_nxt      = step_r;
    was_sel_nxt   = was_sel_r;
    card_mode_nxt = card_mode_r;
    card_op_nxt   = card_op_r;
    xor_nxt       = xor_r;
    echo_nxt      = echo_r;
    sect_hi_nxt   = sect_hi_r;
    sect_lo_nxt   = sect_lo_r;
    ptr_nxt       = ptr_r;
    flag_nxt      = flag_r;
    pad_kind_nxt  = pad_kind_r;
    card_ins_nxt  = card_ins_r;
    reply         = BYTE_IDLE;
    ack           = 1'b0;
    item_we       = 1'b0;

    if (acc) begin
      was_sel_nxt = sel;
      if (sel) begin
        step_nxt = s;
        if (s == 8'd0) begin
          // Command byte picks pad or card
          if (c == CMD_PAD) begin
            step_nxt = 8'd1; card_mode_nxt = 1'b0; ack = 1'b1;
          end else if (c == CMD_CARD && card_ins_r) begin
            step_nxt = 8'd1; card_mode_nxt = 1'b1; ack = 1'b1;
          end
        end else if (!card_mode_r) begin
          // Pad sequence
          if (pad_kind_r == PAD_NONE) begin
            if (s == 8'd1 && c == CMD_POLL) begin
              step_nxt = 8'd2; ack = 1'b1;
            end else begin
              step_nxt = 8'd0;
            end
          end else if (pad_kind_r != PAD_DIGITAL) begin
            step_nxt = 8'd0;
          end else begin
            case (s)
              8'd1: begin
                if (c != CMD_POLL) begin
                  step_nxt = 8'd0;
                end else begin
                  reply = PAD_ID_LO; step_nxt = 8'd2; ack = 1'b1;
                end
              end
              8'd2: begin
                reply = ID_5A; step_nxt = 8'd3; ack = 1'b1;
              end
              8'd3: begin
                if (!in_chan.data.buttons_valid) begin
                  step_nxt = 8'd0;
                end else begin
                  reply = ~in_chan.data.button_bits[7:0]; step_nxt = 8'd4; ack = 1'b1;
                end
              end
              8'd4: begin
                step_nxt = 8'd0;
                if (in_chan.data.buttons_valid) begin
                  reply = ~in_chan.data.button_bits[15:8];
                end
              end
              default: begin
                step_nxt = 8'd0;
              end
            endcase
          end
        end else if (s == 8'd1) begin
          // Card command byte
          reply = flag_r;
          step_nxt = 8'd2;
          ack = 1'b1;
          case (c)
            CMD_READ:  card_op_nxt = OP_READ;
            CMD_ID:    card_op_nxt = OP_ID;
            CMD_WRITE: card_op_nxt = OP_WRITE;
            default: begin
              step_nxt = 8'd0; ack = 1'b0;
            end
          endcase
        end else if (!card_ins_r) begin
          step_nxt = 8'd0;
        end else begin
          case (card_op_r)
            OP_ID: begin
              if (c != BYTE_ZERO || s < 8'd2 || s > 8'd9) begin
                step_nxt = 8'd0;
              end else begin
                reply = id_byte(s[2:0] - 3'd2);
                if (s == 8'd9) begin
                  step_nxt = 8'd0;
                end else begin
                  step_nxt = s_inc; ack = 1'b1;
                end
              end
            end
            OP_READ: begin
              step_nxt = s_inc;
              ack = 1'b1;
              if (s == 8'd4) begin
                reply = BYTE_ZERO; echo_nxt = c; sect_hi_nxt = c[1:0];
                xor_nxt = {6'b0, c[1:0]};
              end else if (s == 8'd5) begin
                reply = echo_r; sect_lo_nxt = c; xor_nxt = xor_r ^ c;
              end else if (c != BYTE_ZERO || s < 8'd2 || s > 8'd139) begin
                step_nxt = 8'd0; ack = 1'b0;
              end else if (s == 8'd2) begin
                reply = ID_5A;
              end else if (s == 8'd3) begin
                reply = ID_5D;
              end else if (s == 8'd6) begin
                reply = ID_5C;
              end else if (s == 8'd7) begin
                reply = ID_5D;
              end else if (s == 8'd8) begin
                reply = {6'b0, sect_hi_r};
              end else if (s == 8'd9) begin
                reply = sect_lo_r; ptr_nxt = base_cur;
              end else if (s <= 8'd137) begin
                // Data byte was prefetched at the current pointer
                reply = ram_rdata; xor_nxt = xor_r ^ ram_rdata;
                ptr_nxt = ptr_r + ADDR_W'(1);
              end else if (s == 8'd138) begin
                reply = xor_r;
              end else begin
                reply = END_GOOD; step_nxt = 8'd0; ack = 1'b0;
              end
            end
            OP_WRITE: begin
              step_nxt = s_inc;
              ack = 1'b1;
              if (s == 8'd2 || s == 8'd3) begin
                if (c != BYTE_ZERO) begin
                  step_nxt = 8'd0; ack = 1'b0;
                end else begin
                  reply = (s == 8'd2) ? ID_5A : ID_5D;
                end
              end else if (s == 8'd4) begin
                reply = BYTE_ZERO; echo_nxt = c; sect_hi_nxt = c[1:0];
                xor_nxt = {6'b0, c[1:0]};
              end else if (s == 8'd5) begin
                reply = echo_r; sect_lo_nxt = c; xor_nxt = xor_r ^ c; echo_nxt = c;
                ptr_nxt = base_new;
              end else if (s >= 8'd6 && s <= 8'd133) begin
                // Store the byte and echo the previous one
                reply = echo_r; echo_nxt = c; item_we = 1'b1;
                ptr_nxt = ptr_r + ADDR_W'(1); xor_nxt = xor_r ^ c;
              end else if (s == 8'd134) begin
                reply = echo_r;
                echo_nxt = (c == xor_r) ? END_GOOD : END_BAD;
              end else if (s == 8'd135 || s == 8'd136) begin
                if (c != BYTE_ZERO) begin
                  step_nxt = 8'd0; ack = 1'b0;
                end else begin
                  reply = (s == 8'd135) ? ID_5C : ID_5D;
                end
              end else if (s == 8'd137) begin
                step_nxt = 8'd0; ack = 1'b0;
                if (c == BYTE_ZERO) begin
                  reply = echo_r;
                  if (echo_r == END_GOOD) begin
                    flag_nxt = flag_r & ~FLAG_FRESH_BIT;
                  end
                end
              end else begin
                step_nxt = 8'd0; ack = 1'b0;
              end
            end
            default: begin
              step_nxt = 8'd0;
            end
          endcase
        end
      end
    end

    // The user must write configuration only while idle; the block itself does not enforce it
    if (cfg_we) begin
      case (cfg_index)
        CFG_PAD_KIND: begin
          if (cfg_data != pad_kind_r) begin
            pad_kind_nxt = cfg_data; step_nxt = 8'd0;
          end
        end
        CFG_CARD_INSERTED: begin
          card_ins_nxt = cfg_data[0]; step_nxt = 8'd0; flag_nxt = FLAG_RESET;
        end
        default: begin
        end
      endcase
    end
  end

  // Card store access: clearing pass first, then item writes at the pointer
  assign ram_we    = clearing_r || item_we;
  assign ram_waddr = clearing_r ? clr_cnt_r : ptr_r;
  assign ram_wdata = clearing_r ? BYTE_ZERO : c;

  pmc_ram #(
    .WIDTH (8),
    .DEPTH (CARD_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_nxt),
    .rdata (ram_rdata)
  );

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 8'd0;
      was_sel_r   <= 1'b0;
      card_mode_r <= 1'b0;
      card_op_r   <= OP_READ;
      xor_r       <= 8'd0;
      echo_r      <= 8'd0;
      sect_hi_r   <= 2'd0;
      sect_lo_r   <= 8'd0;
      ptr_r       <= '0;
      flag_r      <= FLAG_RESET;
      pad_kind_r  <= PAD_NONE;
      card_ins_r  <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      was_sel_r   <= was_sel_nxt;
      card_mode_r <= card_mode_nxt;
      card_op_r   <= card_op_nxt;
      xor_r       <= xor_nxt;
      echo_r      <= echo_nxt;
      sect_hi_r   <= sect_hi_nxt;
      sect_lo_r   <= sect_lo_nxt;
      ptr_r       <= ptr_nxt;
      flag_r      <= flag_nxt;
      pad_kind_r  <= pad_kind_nxt;
      card_ins_r  <= card_ins_nxt;
    end
  end

  // Sweep the store to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (clr_cnt_r == ADDR_W'(CARD_BYTES - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_word_r.reply_byte   <= reply;
      out_word_r.more_follows <= ack;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_word_r;

  // Checks
  `ASSERT_NXT(a_unsel_idle, clk, rst_n, acc && !sel,
    out_chan.valid && out_chan.data.reply_byte == BYTE_IDLE && !out_chan.data.more_follows)
  `ASSERT_NXT(a_nack_restarts, clk, rst_n, acc && sel && !ack, step_r == 8'd0)
  `ASSERT_NXT(a_ptr_follows_write, clk, rst_n, !clearing_r && ram_we,
    ptr_r == $past(ptr_r) + ADDR_W'(1))
  `ASSERT_IMP(a_no_take_while_clearing, clk, rst_n, clearing_r, !acc && ram_we)

endmodule
